FILE: rtl/cvf_pkg.sv
`timescale 1ns / 1ps
// cvf_pkg: shared types and constants for the 3x3 convolution filter.
// No dependencies; used by every other file of the block but cvf_queue.
package cvf_pkg;

  // Default geometry and pixel depth, handed to the top-level parameters
  localparam int MAX_SIDE_DEF   = 512;
  localparam int PIXEL_BITS_DEF = 16;

  // Side length both geometry registers take at reset (clamped to MAX_SIDE)
  localparam int SIDE_RST       = 512;

  // Fixed field widths
  localparam int FIELD_PIX_BITS = 16;
  localparam int TAP_BITS       = 16;
  localparam int TAPS_BITS      = 3 * TAP_BITS;
  localparam int SUM_BITS       = 36;
  localparam int POS_BITS       = 9;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_SIDE_BITS  = 10;

  // Slots between the front and back halves
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [TAPS_BITS-1:0] TAPS_LEFT_RST   = 48'h0000_0000_0000;
  localparam logic [TAPS_BITS-1:0] TAPS_CENTER_RST = 48'h0000_0001_0000;
  localparam logic [TAPS_BITS-1:0] TAPS_RIGHT_RST  = 48'h0000_0000_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TAPS_LEFT    = 3'd0,
    REG_TAPS_CENTER  = 3'd1,
    REG_TAPS_RIGHT   = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

  // Position tag that travels with each window
  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } cvf_meta_t;

endpackage

FILE: rtl/cvf_if.sv
`timescale 1ns / 1ps
// cvf_if: valid/ready stream interfaces for pixels in and sums out.
// Depends on cvf_pkg for field widths.
interface cvf_pix_if;
  logic                                valid;
  logic                                ready;
  logic [cvf_pkg::FIELD_PIX_BITS-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface cvf_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [cvf_pkg::SUM_BITS-1:0] sum;
  logic [cvf_pkg::POS_BITS-1:0]        out_row;
  logic [cvf_pkg::POS_BITS-1:0]        out_col;
  logic                                last;

  modport source (output valid, output sum, output out_row, output out_col, output last,
                  input ready);
  modport sink   (input valid, input sum, input out_row, input out_col, input last,
                  output ready);
endinterface

FILE: rtl/cvf_queue.sv
`timescale 1ns / 1ps
// cvf_queue: small register FIFO between the front and back halves.
// Depends on nothing; the producer never pushes when full (credit on count).
module cvf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic                         valid,
  output logic [WIDTH-1:0]             data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_pop;

  assign valid  = (count_r != '0);
  assign data   = slot_r[rptr_r];
  assign count  = count_r;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/cvf_front.sv
`timescale 1ns / 1ps
// cvf_front: pixel intake, raster counters, line buffers and 3x3 window.
// Depends on cvf_pkg and cvf_if; emits one window per interior pixel.
module cvf_front #(
  parameter int MAX_SIDE    = cvf_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS  = cvf_pkg::PIXEL_BITS_DEF,
  parameter int QUEUE_DEPTH = cvf_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  cvf_pix_if.sink                            in_px,
  input  logic [$clog2(MAX_SIDE)-1:0]        col_last,
  input  logic [$clog2(MAX_SIDE)-1:0]        row_last,
  input  logic                               restart,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count,
  output logic                               push_valid,
  output logic [8:0][PIXEL_BITS-1:0]         job_pix,
  output cvf_pkg::cvf_meta_t                 job_meta
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int PB = PIXEL_BITS;

  logic [AW-1:0]      col_r, row_r, col_nxt, row_nxt;
  logic               accept;
  logic               a_v_r;
  logic [PB-1:0]      a_px_r;
  logic [AW-1:0]      a_col_r, a_row_r;
  logic [2*PB-1:0]    rd_r;
  logic [2*PB-1:0]    lbuf [MAX_SIDE];
  logic [5:0][PB-1:0] win_r;
  logic [PB-1:0]      top, mid;

  // Room for this pixel plus the one already in the read stage
  assign in_px.ready = (int'(q_count) + int'(a_v_r)) < QUEUE_DEPTH;
  assign accept      = in_px.valid && in_px.ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_r == col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last) ? '0 : row_r + AW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      a_v_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      a_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px_r  <= in_px.pixel[PB-1:0];
      a_col_r <= col_r;
      a_row_r <= row_r;
    end
  end

  // Line buffers: upper half two rows up, lower half one row up.
  // Read column c on transfer, write it back the next cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= lbuf[col_r];
    end
    if (a_v_r) begin
      lbuf[a_col_r] <= {rd_r[PB-1:0], a_px_r};
    end
  end

  assign top = rd_r[2*PB-1:PB];
  assign mid = rd_r[PB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (a_v_r) begin
      win_r[2:0] <= win_r[5:3];
      win_r[3]   <= top;
      win_r[4]   <= mid;
      win_r[5]   <= a_px_r;
    end
  end

  assign push_valid = a_v_r && (a_row_r >= AW'(2)) && (a_col_r >= AW'(2));

  always_comb begin
    job_pix[5:0] = win_r;
    job_pix[6]   = top;
    job_pix[7]   = mid;
    job_pix[8]   = a_px_r;
    job_meta.row  = cvf_pkg::POS_BITS'(a_row_r - AW'(1));
    job_meta.col  = cvf_pkg::POS_BITS'(a_col_r - AW'(1));
    job_meta.last = (a_row_r == row_last) && (a_col_r == col_last);
  end

endmodule

FILE: rtl/cvf_back.sv
`timescale 1ns / 1ps
// cvf_back: multiply, column sums, total sum and output register.
// Depends on cvf_pkg and cvf_if; the whole pipe holds while the output stalls.
module cvf_back #(
  parameter int PIXEL_BITS = cvf_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  logic [8:0][PIXEL_BITS-1:0]         q_pix,
  input  cvf_pkg::cvf_meta_t                 q_meta,
  output logic                               q_pop,
  input  logic [2:0][cvf_pkg::TAPS_BITS-1:0] taps,
  cvf_res_if.source                          out_res
);

  localparam int PB  = PIXEL_BITS;
  localparam int TB  = cvf_pkg::TAP_BITS;
  localparam int PRW = TB + PB + 1;
  localparam int CSW = PRW + 2;
  localparam int ACW = PRW + 4;

  logic                              en;
  logic                              m_v_r, s_v_r, o_v_r;
  cvf_pkg::cvf_meta_t                m_meta_r, s_meta_r, o_meta_r;
  logic signed [PRW-1:0]             prod_r [9];
  logic signed [CSW-1:0]             cs_r [3];
  logic signed [ACW-1:0]             total;
  logic signed [cvf_pkg::SUM_BITS-1:0] sum_r;

  assign en    = !o_v_r || out_res.ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= q_valid;
      s_v_r <= m_v_r;
      o_v_r <= s_v_r;
    end
  end

  // Product k: column k/3 (left, centre, right), slot k%3 (above, same, below)
  for (genvar k = 0; k < 9; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[k] <= $signed(taps[k/3][TB*(k%3) +: TB]) * $signed({1'b0, q_pix[k]});
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_col
    always_ff @(posedge clk) begin
      if (en) begin
        cs_r[c] <= CSW'(prod_r[3*c]) + CSW'(prod_r[3*c+1]) + CSW'(prod_r[3*c+2]);
      end
    end
  end

  assign total = ACW'(cs_r[0]) + ACW'(cs_r[1]) + ACW'(cs_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      m_meta_r <= q_meta;
      s_meta_r <= m_meta_r;
      o_meta_r <= s_meta_r;
      sum_r    <= cvf_pkg::SUM_BITS'(total);
    end
  end

  assign out_res.valid   = o_v_r;
  assign out_res.sum     = sum_r;
  assign out_res.out_row = o_meta_r.row;
  assign out_res.out_col = o_meta_r.col;
  assign out_res.last    = o_meta_r.last;

endmodule

FILE: rtl/conv3x3_image_filter.sv
`timescale 1ns / 1ps
// conv3x3_image_filter: top level of the streaming 3x3 convolution filter.
// Depends on cvf_pkg, cvf_if, cvf_queue, cvf_front and cvf_back.
//
// Usage
//   in_px   : grey pixels in raster order, one transfer per pixel.
//   out_res : one weighted 3x3 sum per interior pixel, tagged with row and
//             column; last marks the final interior pixel of the image.
//             Border pixels give nothing.
//   cfg_*   : write-only registers (taps, width, height), written while idle.
//             Writing width or height restarts the raster at (0, 0).
// Timing
//   One pixel per cycle sustained while out_res takes results. The sum for (r-1, c-1)
//   passes these registers after pixel (r, c) is taken: the line buffer read shares the
//   accepting edge, then queue, multiply, column sums, output register.
//   The line buffer has one read and one write port, used once per pixel each.
// Reset
//   Counters, window and pipe valids clear; taps default to identity and the
//   geometry to 512 by 512 (MAX_SIDE if smaller). Line buffers are not cleared.
// Back-pressure
//   With out_res stalled the back pipe holds; the front keeps taking pixels
//   until the four-entry queue plus its read stage are full.
module conv3x3_image_filter #(
  parameter int MAX_SIDE   = cvf_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = cvf_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  cvf_pix_if.sink                             in_px,
  cvf_res_if.source                           out_res,
  input  logic                                cfg_we,
  input  logic [cvf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cvf_pkg::TAPS_BITS-1:0]       cfg_data
);

  localparam int AW  = $clog2(MAX_SIDE);
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int QD  = cvf_pkg::QUEUE_DEPTH;
  localparam int QCW = $clog2(QD + 1);
  localparam int MW  = $bits(cvf_pkg::cvf_meta_t);
  localparam int JW  = 9 * PIXEL_BITS + MW;
  // last index after reset: reset side clamped to MAX_SIDE
  localparam int RST_LAST = ((MAX_SIDE < cvf_pkg::SIDE_RST) ? MAX_SIDE : cvf_pkg::SIDE_RST) - 1;

  logic [2:0][cvf_pkg::TAPS_BITS-1:0] taps_r;
  logic [AW-1:0]                      col_last_r, row_last_r;
  logic                               restart;
  logic [cvf_pkg::CFG_SIDE_BITS-1:0]  side_raw;
  logic [SW-1:0]                      side;
  logic [AW-1:0]                      side_last;

  logic                               push_valid;
  logic [8:0][PIXEL_BITS-1:0]         job_pix;
  cvf_pkg::cvf_meta_t                 job_meta;
  logic [QCW-1:0]                     q_count;
  logic                               q_valid, q_pop;
  logic [JW-1:0]                      q_data;
  logic [8:0][PIXEL_BITS-1:0]         q_pix;
  cvf_pkg::cvf_meta_t                 q_meta;

  // Geometry written as a side length, clamped, kept as last index
  assign side_raw = cfg_data[cvf_pkg::CFG_SIDE_BITS-1:0];

  always_comb begin
    if (int'(side_raw) < 3) begin
      side = SW'(3);
    end else if (int'(side_raw) > MAX_SIDE) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = SW'(side_raw);
    end
    side_last = AW'(side - SW'(1));
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        cvf_pkg::REG_IMAGE_WIDTH,
        cvf_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
        default:                   restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r[0]  <= cvf_pkg::TAPS_LEFT_RST;
      taps_r[1]  <= cvf_pkg::TAPS_CENTER_RST;
      taps_r[2]  <= cvf_pkg::TAPS_RIGHT_RST;
      col_last_r <= AW'(RST_LAST);
      row_last_r <= AW'(RST_LAST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cvf_pkg::REG_TAPS_LEFT:    taps_r[0]  <= cfg_data;
        cvf_pkg::REG_TAPS_CENTER:  taps_r[1]  <= cfg_data;
        cvf_pkg::REG_TAPS_RIGHT:   taps_r[2]  <= cfg_data;
        cvf_pkg::REG_IMAGE_WIDTH:  col_last_r <= side_last;
        cvf_pkg::REG_IMAGE_HEIGHT: row_last_r <= side_last;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Front: intake, line buffers, window
  cvf_front #(
    .MAX_SIDE    (MAX_SIDE),
    .PIXEL_BITS  (PIXEL_BITS),
    .QUEUE_DEPTH (QD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_px      (in_px),
    .col_last   (col_last_r),
    .row_last   (row_last_r),
    .restart    (restart),
    .q_count    (q_count),
    .push_valid (push_valid),
    .job_pix    (job_pix),
    .job_meta   (job_meta)
  );

  // Queue between the halves: windows with their position tag
  cvf_queue #(
    .WIDTH (JW),
    .DEPTH (QD)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({job_meta, job_pix}),
    .pop       (q_pop),
    .valid     (q_valid),
    .data      (q_data),
    .count     (q_count)
  );

  assign q_pix  = q_data[9*PIXEL_BITS-1:0];
  assign q_meta = q_data[JW-1:9*PIXEL_BITS];

  // Back: multiply-accumulate and output register
  cvf_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pix   (q_pix),
    .q_meta  (q_meta),
    .q_pop   (q_pop),
    .taps    (taps_r),
    .out_res (out_res)
  );

endmodule

FILE: sim/tb_conv3x3_image_filter.sv
`timescale 1ns / 1ps
// tb_conv3x3_image_filter: self-checking bench for the streaming 3x3 convolution filter.
// Plans pixel transfers and register writes, predicts every sum from its own line buffer
// and window model, and checks each result transfer. Needs cvf_pkg, cvf_if and the RTL.
module tb_conv3x3_image_filter;

  localparam int MAX_SIDE       = cvf_pkg::MAX_SIDE_DEF;
  localparam int FIELD_PIX_BITS = cvf_pkg::FIELD_PIX_BITS;
  localparam int TAP_BITS       = cvf_pkg::TAP_BITS;
  localparam int TAPS_BITS      = cvf_pkg::TAPS_BITS;
  localparam int SUM_BITS       = cvf_pkg::SUM_BITS;
  localparam int POS_BITS       = cvf_pkg::POS_BITS;
  localparam int CFG_IDX_BITS   = cvf_pkg::CFG_IDX_BITS;
  localparam int CFG_SIDE_BITS  = cvf_pkg::CFG_SIDE_BITS;
  localparam int REG_SPACE      = 1 << CFG_IDX_BITS;
  localparam int RANDOM_ITEMS   = 1550;
  // read stage, queue and three back stages; give it a little more before a write
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int STALL_LIMIT    = 4000;
  // random phase that carries one full image at the widest or the tallest geometry
  localparam int BIG_PHASE      = 0;

  typedef enum logic [1:0] {OP_PIXEL, OP_WRITE, OP_HOLD} plan_op_t;

  typedef struct {
    plan_op_t                  op;
    logic [FIELD_PIX_BITS-1:0] pixel;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [TAPS_BITS-1:0]      data;
  } plan_item_t;

  typedef struct {
    logic [SUM_BITS-1:0] sum;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } window_sum_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [TAPS_BITS-1:0]    cfg_data;

  cvf_pix_if px_if ();
  cvf_res_if res_if ();

  conv3x3_image_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (px_if),
    .out_res   (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Filter model: registers, two row buffers, 3x2 window and raster position.
  // Row buffers are only ever read for a sum once rows 0 and 1 of the current
  // image have filled them, so their start-up contents never matter.
  // ---------------------------------------------------------------------------
  logic [TAPS_BITS-1:0]      w_left, w_centre, w_right;
  int                        geom_w, geom_h;
  logic [FIELD_PIX_BITS-1:0] rows_far  [MAX_SIDE];
  logic [FIELD_PIX_BITS-1:0] rows_near [MAX_SIDE];
  // 0..2: column j-1, 3..5: column j; each above, same row, below
  logic [FIELD_PIX_BITS-1:0] win [6];
  int                        at_row, at_col;

  plan_item_t  stream_plan[$];  // pixels, writes and holds still to go out
  window_sum_t sums_due[$];     // predicted sums not yet seen on out_res

  int   pix_total = 0;
  int   pix_done = 0;
  int   quiet = 0;       // cycles since the last pixel transfer
  int   failures = 0;
  int   idle_cycles = 0;
  logic pix_moved = 1'b0;

  function automatic int side_of(input logic [CFG_SIDE_BITS-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic longint weigh_column(input logic [TAPS_BITS-1:0] taps,
                                          input logic [FIELD_PIX_BITS-1:0] above,
                                          input logic [FIELD_PIX_BITS-1:0] same,
                                          input logic [FIELD_PIX_BITS-1:0] below);
    longint w_above, w_same, w_below;
    w_above = longint'($signed(taps[TAP_BITS-1:0]));
    w_same  = longint'($signed(taps[2*TAP_BITS-1:TAP_BITS]));
    w_below = longint'($signed(taps[3*TAP_BITS-1:2*TAP_BITS]));
    return w_above * longint'(above) + w_same * longint'(same) + w_below * longint'(below);
  endfunction

  // Model one accepted pixel; the sum for (r-1, c-1) falls due at pixel (r, c).
  task automatic take_pixel(input logic [FIELD_PIX_BITS-1:0] pix);
    logic [FIELD_PIX_BITS-1:0] top, mid;
    longint                    acc;
    window_sum_t               due;
    top = rows_far[at_col];
    mid = rows_near[at_col];
    if (at_row >= 2 && at_col >= 2) begin
      acc = weigh_column(w_left, win[0], win[1], win[2])
          + weigh_column(w_centre, win[3], win[4], win[5])
          + weigh_column(w_right, top, mid, pix);
      due.sum  = acc[SUM_BITS-1:0];
      due.row  = POS_BITS'(at_row - 1);
      due.col  = POS_BITS'(at_col - 1);
      due.last = (at_row == geom_h - 1) && (at_col == geom_w - 1);
      sums_due.push_back(due);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = pix;
    rows_far[at_col]  = mid;
    rows_near[at_col] = pix;
    at_col++;
    if (at_col >= geom_w) begin
      at_col = 0;
      at_row++;
      if (at_row >= geom_h) at_row = 0;
    end
  endtask

  task automatic apply_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [TAPS_BITS-1:0] data);
    case (idx)
      cvf_pkg::REG_TAPS_LEFT:   w_left   = data;
      cvf_pkg::REG_TAPS_CENTER: w_centre = data;
      cvf_pkg::REG_TAPS_RIGHT:  w_right  = data;
      // geometry writes restart the raster; row buffers keep their contents
      cvf_pkg::REG_IMAGE_WIDTH: begin
        geom_w = side_of(data[CFG_SIDE_BITS-1:0]);
        at_row = 0;
        at_col = 0;
      end
      cvf_pkg::REG_IMAGE_HEIGHT: begin
        geom_h = side_of(data[CFG_SIDE_BITS-1:0]);
        at_row = 0;
        at_col = 0;
      end
      default: ;  // unmapped index, no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus planning
  // ---------------------------------------------------------------------------
  task automatic plan_pixel(input logic [FIELD_PIX_BITS-1:0] pix);
    plan_item_t it;
    it.op    = OP_PIXEL;
    it.pixel = pix;
    it.idx   = '0;
    it.data  = '0;
    stream_plan.push_back(it);
    pix_total++;
  endtask

  task automatic plan_write(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [TAPS_BITS-1:0] data);
    plan_item_t it;
    it.op    = OP_WRITE;
    it.pixel = '0;
    it.idx   = idx;
    it.data  = data;
    stream_plan.push_back(it);
  endtask

  // sender holds off until every predicted sum has come back
  task automatic plan_hold();
    plan_item_t it;
    it.op    = OP_HOLD;
    it.pixel = '0;
    it.idx   = '0;
    it.data  = '0;
    stream_plan.push_back(it);
  endtask

  function automatic logic [FIELD_PIX_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return FIELD_PIX_BITS'($urandom);
    endcase
  endfunction

  // Weights lean on the extremes so the sum reaches both ends of its range.
  function automatic logic [TAPS_BITS-1:0] rand_taps();
    logic [TAPS_BITS-1:0] word;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0:       word[k*TAP_BITS +: TAP_BITS] = 16'h8000;
        1:       word[k*TAP_BITS +: TAP_BITS] = 16'h7fff;
        2:       word[k*TAP_BITS +: TAP_BITS] = 16'h0000;
        3:       word[k*TAP_BITS +: TAP_BITS] = 16'hffff;
        4:       word[k*TAP_BITS +: TAP_BITS] = 16'h0001;
        default: word[k*TAP_BITS +: TAP_BITS] = TAP_BITS'($urandom);
      endcase
    end
    return word;
  endfunction

  // geometry value with junk above the side field
  function automatic logic [TAPS_BITS-1:0] geom_word(input logic [CFG_SIDE_BITS-1:0] side);
    logic [TAPS_BITS-1:0] word;
    word = TAPS_BITS'({$urandom, $urandom});
    word[CFG_SIDE_BITS-1:0] = side;
    return word;
  endfunction

  // mostly small sides; now and then below 3 or above MAX_SIDE to hit the clamp
  function automatic logic [CFG_SIDE_BITS-1:0] pick_side();
    case ($urandom_range(0, 15))
      0:       return CFG_SIDE_BITS'($urandom_range(0, 2));
      1:       return CFG_SIDE_BITS'($urandom_range(MAX_SIDE + 1, (1 << CFG_SIDE_BITS) - 1));
      2:       return CFG_SIDE_BITS'($urandom_range(13, 40));
      default: return CFG_SIDE_BITS'($urandom_range(3, 12));
    endcase
  endfunction

  // idle: nothing owed on out_res and the front has had time to empty
  function automatic logic block_quiet();
    return sums_due.size() == 0 && quiet >= SETTLE_CYCLES;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    forever begin
      #6 clk = ~clk;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: works off the head of the plan at each falling edge. A pixel whose
  // valid is up and not yet taken stays up. Register writes wait for idle.
  // Idling: sender light / receiver heavy for the first third of the pixels,
  // then the other way round, then none at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_inputs
    logic                      nx_valid, nx_we, nx_ready;
    logic [FIELD_PIX_BITS-1:0] nx_pixel;
    logic [CFG_IDX_BITS-1:0]   nx_idx;
    logic [TAPS_BITS-1:0]      nx_data;
    int                        src_pct, snk_pct;
    if (pix_done * 3 < pix_total) begin
      src_pct = 12;
      snk_pct = 70;
    end else if (pix_done * 3 < pix_total * 2) begin
      src_pct = 70;
      snk_pct = 12;
    end else begin
      src_pct = 0;
      snk_pct = 0;
    end
    nx_valid = 1'b0;
    nx_we    = 1'b0;
    nx_pixel = px_if.pixel;
    nx_idx   = cfg_index;
    nx_data  = cfg_data;
    nx_ready = rst_n && ($urandom_range(0, 99) >= snk_pct);
    if (rst_n && stream_plan.size() != 0) begin
      case (stream_plan[0].op)
        OP_PIXEL: begin
          nx_pixel = stream_plan[0].pixel;
          nx_valid = (px_if.valid && !pix_moved) || ($urandom_range(0, 99) >= src_pct);
        end
        OP_WRITE: if (block_quiet()) begin
          nx_we   = 1'b1;
          nx_idx  = stream_plan[0].idx;
          nx_data = stream_plan[0].data;
        end
        default: ;  // hold: valid stays low
      endcase
    end
    px_if.valid  <= nx_valid;
    px_if.pixel  <= nx_pixel;
    cfg_we       <= nx_we;
    cfg_index    <= nx_idx;
    cfg_data     <= nx_data;
    res_if.ready <= nx_ready;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, checks a result transfer against the oldest
  // prediction, then feeds a pixel transfer or a register write to the model.
  // The result is handled first; it can never depend on a pixel taken at the
  // same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    window_sum_t want;
    pix_moved = 1'b0;
    if (!rst_n) begin
      w_left   = cvf_pkg::TAPS_LEFT_RST;
      w_centre = cvf_pkg::TAPS_CENTER_RST;
      w_right  = cvf_pkg::TAPS_RIGHT_RST;
      geom_w   = MAX_SIDE;
      geom_h   = MAX_SIDE;
      for (int k = 0; k < 6; k++) win[k] = '0;
      at_row = 0;
      at_col = 0;
      quiet  = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (sums_due.size() == 0) begin
          failures++;
          $display("%0t unexpected sum: expected none, got %0d at (%0d,%0d) last %0b",
                   $time, res_if.sum, res_if.out_row, res_if.out_col, res_if.last);
        end else begin
          want = sums_due.pop_front();
          if (res_if.sum !== want.sum) begin
            failures++;
            $display("%0t sum at (%0d,%0d): expected %0d, got %0d", $time, want.row, want.col,
                     $signed(want.sum), res_if.sum);
          end
          if (res_if.out_row !== want.row) begin
            failures++;
            $display("%0t out_row: expected %0d, got %0d", $time, want.row, res_if.out_row);
          end
          if (res_if.out_col !== want.col) begin
            failures++;
            $display("%0t out_col: expected %0d, got %0d", $time, want.col, res_if.out_col);
          end
          if (res_if.last !== want.last) begin
            failures++;
            $display("%0t last at (%0d,%0d): expected %0b, got %0b", $time, want.row, want.col,
                     want.last, res_if.last);
          end
        end
      end
      if (px_if.valid && px_if.ready) begin
        take_pixel(px_if.pixel);
        stream_plan.delete(0);
        pix_moved = 1'b1;
        pix_done++;
        quiet = 0;
      end else begin
        if (cfg_we) begin
          apply_write(cfg_index, cfg_data);
          stream_plan.delete(0);
        end else if (stream_plan.size() != 0 && stream_plan[0].op == OP_HOLD && block_quiet()) begin
          stream_plan.delete(0);
        end
        if (quiet < SETTLE_CYCLES) quiet++;
      end
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (px_if.valid && px_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[conv3x3_image_filter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [FIELD_PIX_BITS-1:0] sample [9];
    logic [CFG_SIDE_BITS-1:0]  side;
    int                        gw, gh, n, hold_at, phase, planned;

    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    px_if.valid  = 1'b0;
    px_if.pixel  = '0;
    res_if.ready = 1'b0;
    sample = '{16'h0000, 16'hffff, 16'h8000, 16'h0001, 16'h7fff,
               16'h1234, 16'hfffe, 16'h00ff, 16'hff00};

    // Directed: 3x3 images, written as 0 and 2 so both clamp up to 3.
    // Most negative weights on full-scale pixels give the lowest sum.
    plan_write(cvf_pkg::REG_IMAGE_WIDTH, geom_word(CFG_SIDE_BITS'(0)));
    plan_write(cvf_pkg::REG_IMAGE_HEIGHT, geom_word(CFG_SIDE_BITS'(2)));
    plan_write(cvf_pkg::REG_TAPS_LEFT, 48'h8000_8000_8000);
    plan_write(cvf_pkg::REG_TAPS_CENTER, 48'h8000_8000_8000);
    plan_write(cvf_pkg::REG_TAPS_RIGHT, 48'h8000_8000_8000);
    repeat (9) plan_pixel(16'hffff);
    plan_hold();
    // tap change keeps the raster position; raster has wrapped to (0, 0) here
    plan_write(cvf_pkg::REG_TAPS_LEFT, 48'h7fff_7fff_7fff);
    plan_write(cvf_pkg::REG_TAPS_CENTER, 48'h7fff_7fff_7fff);
    plan_write(cvf_pkg::REG_TAPS_RIGHT, 48'h7fff_7fff_7fff);
    repeat (9) plan_pixel(16'hffff);
    // unmapped indexes must be ignored
    for (int idx = int'(cvf_pkg::REG_IMAGE_HEIGHT) + 1; idx < REG_SPACE; idx++)
      plan_write(CFG_IDX_BITS'(idx), TAPS_BITS'({$urandom, $urandom}));
    // distinct weights per slot pin down the tap ordering
    plan_write(cvf_pkg::REG_TAPS_LEFT, 48'h0003_0002_0001);
    plan_write(cvf_pkg::REG_TAPS_CENTER, 48'h0006_0005_0004);
    plan_write(cvf_pkg::REG_TAPS_RIGHT, 48'h0009_0008_0007);
    for (int k = 0; k < 9; k++) plan_pixel(sample[k]);

    // Random phases: new taps and geometry now and then, then whole images or
    // a partial stretch. One phase carries a full image at the largest width
    // or the largest height to reach the top bits of out_col or out_row.
    gw = 3;
    gh = 3;
    planned = 0;
    phase = 0;
    while (planned < RANDOM_ITEMS) begin
      if (phase == BIG_PHASE) begin
        plan_write(cvf_pkg::REG_TAPS_LEFT, rand_taps());
        plan_write(cvf_pkg::REG_TAPS_CENTER, rand_taps());
        plan_write(cvf_pkg::REG_TAPS_RIGHT, rand_taps());
        if ($urandom_range(0, 1)) begin
          // largest side value, clamped down to MAX_SIDE
          plan_write(cvf_pkg::REG_IMAGE_WIDTH,
                     geom_word(CFG_SIDE_BITS'((1 << CFG_SIDE_BITS) - 1)));
          plan_write(cvf_pkg::REG_IMAGE_HEIGHT, geom_word(CFG_SIDE_BITS'(3)));
          gw = MAX_SIDE;
          gh = 3;
        end else begin
          plan_write(cvf_pkg::REG_IMAGE_WIDTH, geom_word(CFG_SIDE_BITS'(3)));
          plan_write(cvf_pkg::REG_IMAGE_HEIGHT, geom_word(CFG_SIDE_BITS'(MAX_SIDE)));
          gw = 3;
          gh = MAX_SIDE;
        end
        repeat (3 * MAX_SIDE) plan_pixel(rand_pixel());
        planned += 3 * MAX_SIDE;
      end else begin
        if ($urandom_range(0, 1)) plan_write(cvf_pkg::REG_TAPS_LEFT, rand_taps());
        if ($urandom_range(0, 1)) plan_write(cvf_pkg::REG_TAPS_CENTER, rand_taps());
        if ($urandom_range(0, 1)) plan_write(cvf_pkg::REG_TAPS_RIGHT, rand_taps());
        if ($urandom_range(0, 7) == 0)
          plan_write(CFG_IDX_BITS'($urandom_range(int'(cvf_pkg::REG_IMAGE_HEIGHT) + 1,
                                                  REG_SPACE - 1)),
                     TAPS_BITS'({$urandom, $urandom}));
        if ($urandom_range(0, 2) == 0) begin
          side = pick_side();
          plan_write(cvf_pkg::REG_IMAGE_WIDTH, geom_word(side));
          gw = side_of(side);
        end
        if ($urandom_range(0, 2) == 0) begin
          side = pick_side();
          plan_write(cvf_pkg::REG_IMAGE_HEIGHT, geom_word(side));
          gh = side_of(side);
        end
        // small geometry: one or two whole images; else a partial stretch
        if (gw * gh <= 150 && $urandom_range(0, 3) != 0)
          n = gw * gh * $urandom_range(1, 2);
        else
          n = $urandom_range(1, 60);
        hold_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++) begin
          if (i == hold_at) plan_hold();
          plan_pixel(rand_pixel());
        end
        planned += n;
      end
      phase++;
    end

    // synchronous reset, released at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stream_plan.size() != 0 || sums_due.size() != 0) @(posedge clk);
    // any stray result would show up in this tail
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("[conv3x3_image_filter] OK");
    else
      $display("[conv3x3_image_filter] ERROR");
    $finish;
  end

endmodule
